FILE: hw/rtl/vasf_pkg.sv
// shared types and constants for the voice allocator
package vasf_pkg;

  localparam int SRC_W   = 8;
  localparam int LOUD_W  = 16;
  localparam int ACT_W   = 3;
  localparam int VOICE_W = 5;
  localparam int CFG_W   = 6;
  localparam int GROUP_SIZE = 8;

  localparam logic [LOUD_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [CFG_W-1:0]  VOICES_IN_USE_RESET = 6'd32;
  localparam logic [2:0]        ADDR_VOICES_IN_USE = 3'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_RETIRED  = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_FREE     = 3'd3,
    ACT_STOLE    = 3'd4,
    ACT_REJECTED = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } back_state_t;

  typedef struct packed {
    logic              in_range;
    logic [SRC_W-1:0]  src;
    logic [LOUD_W-1:0] loud;
  } item_t;

endpackage

FILE: hw/rtl/vasf_front.sv
// front end: range check and a two-entry event queue
module vasf_front #(
  parameter int NUM_SOURCES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [vasf_pkg::SRC_W-1:0]  source_id,
  input  logic [vasf_pkg::LOUD_W-1:0] loudness,
  output logic                       q_valid,
  output vasf_pkg::item_t            q_item,
  input  logic                       q_pop
);
  import vasf_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  item_t      in_item;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_comb begin
    in_item.in_range = ({24'd0, source_id} < 32'(NUM_SOURCES));
    in_item.src      = source_id;
    in_item.loud     = loudness;
  end

  always_comb begin
    count_next = count;
    if (push && !(q_pop && q_valid)) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

endmodule

FILE: hw/rtl/vasf_back.sv
// back end: voice table, free and faintest scans, allocation and result register
module vasf_back #(
  parameter int NUM_VOICES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vasf_pkg::CFG_W-1:0]   voices_in_use,
  input  logic                        q_valid,
  input  vasf_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vasf_pkg::ACT_W-1:0]   action,
  output logic [vasf_pkg::VOICE_W-1:0] voice,
  output logic [vasf_pkg::SRC_W-1:0]   evicted_source
);
  import vasf_pkg::*;

  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int NUM_GROUPS = (NUM_VOICES + GROUP_SIZE - 1) / GROUP_SIZE;

  back_state_t state;
  back_state_t state_next;
  logic        fin;

  logic              owner_valid [NUM_VOICES];
  logic [SRC_W-1:0]  owner_id    [NUM_VOICES];
  logic [LOUD_W-1:0] voice_loud  [NUM_VOICES];

  item_t item;
  logic [CFG_W-1:0] n_active;

  logic [NUM_VOICES-1:0] match_vec;
  logic [VIDX_W-1:0]     match_idx;
  logic                  free_any;
  logic [VIDX_W-1:0]     free_idx;
  logic [LOUD_W-1:0]     gmin [NUM_GROUPS];
  logic [VIDX_W-1:0]     gidx [NUM_GROUPS];

  logic                  match_any_q;
  logic [VIDX_W-1:0]     match_idx_q;
  logic                  free_any_q;
  logic [VIDX_W-1:0]     free_idx_q;
  logic [LOUD_W-1:0]     gmin_q [NUM_GROUPS];
  logic [VIDX_W-1:0]     gidx_q [NUM_GROUPS];

  logic [LOUD_W-1:0] faint;
  logic [VIDX_W-1:0] pick;
  action_t           res_action;
  logic [VIDX_W-1:0] res_voice;
  logic [SRC_W-1:0]  res_evicted;
  logic              wr_en;
  logic [VIDX_W-1:0] wr_idx;
  logic              wr_valid;
  logic [LOUD_W-1:0] wr_loud;
  logic              out_valid_next;

  assign n_active = (voices_in_use > CFG_W'(NUM_VOICES)) ? CFG_W'(NUM_VOICES) : voices_in_use;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) begin
        state_next = ST_SCAN;
      end
      ST_SCAN:  state_next = ST_APPLY;
      ST_APPLY: if (fin) begin
        state_next = q_valid ? ST_SCAN : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fin   = 1'b0;
    q_pop = 1'b0;
    case (state)
      ST_IDLE:  q_pop = q_valid;
      ST_SCAN:  q_pop = 1'b0;
      ST_APPLY: begin
        fin   = !out_valid || !out_stall;
        q_pop = fin && q_valid;
      end
      default:  q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
  end

  // scan of the voice table
  always_comb begin
    int v;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      match_vec[i] = owner_valid[i] && (owner_id[i] == item.src);
      if (match_vec[i]) begin
        match_idx = match_idx | VIDX_W'(i);
      end
    end
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if ((CFG_W'(i) < n_active) && !owner_valid[i]) begin
        free_any = 1'b1;
        free_idx = VIDX_W'(i);
      end
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gmin[g] = FULL_SCALE;
      gidx[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        v = g * GROUP_SIZE + k;
        if (v < NUM_VOICES) begin
          if ((CFG_W'(v) < n_active) && owner_valid[v] && (voice_loud[v] < gmin[g])) begin
            gmin[g] = voice_loud[v];
            gidx[g] = VIDX_W'(v);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      match_any_q <= |match_vec;
      match_idx_q <= match_idx;
      free_any_q  <= free_any;
      free_idx_q  <= free_idx;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        gmin_q[g] <= gmin[g];
        gidx_q[g] <= gidx[g];
      end
    end
  end

  // decision
  always_comb begin
    faint = FULL_SCALE;
    pick  = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (gmin_q[g] < faint) begin
        faint = gmin_q[g];
        pick  = gidx_q[g];
      end
    end
    res_action  = ACT_NONE;
    res_voice   = '0;
    res_evicted = '0;
    wr_en       = 1'b0;
    wr_idx      = '0;
    wr_valid    = 1'b0;
    wr_loud     = item.loud;
    if (item.in_range) begin
      if (item.loud == '0) begin
        if (match_any_q) begin
          res_action = ACT_RETIRED;
          res_voice  = match_idx_q;
          wr_en      = 1'b1;
          wr_idx     = match_idx_q;
        end
      end else if (match_any_q) begin
        res_action = ACT_KEPT;
        res_voice  = match_idx_q;
        wr_en      = 1'b1;
        wr_idx     = match_idx_q;
        wr_valid   = 1'b1;
      end else if (free_any_q) begin
        res_action = ACT_FREE;
        res_voice  = free_idx_q;
        wr_en      = 1'b1;
        wr_idx     = free_idx_q;
        wr_valid   = 1'b1;
      end else if ((n_active != '0) && (faint < item.loud)) begin
        res_action  = ACT_STOLE;
        res_voice   = pick;
        res_evicted = owner_id[pick];
        wr_en       = 1'b1;
        wr_idx      = pick;
        wr_valid    = 1'b1;
      end else begin
        res_action = ACT_REJECTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        owner_valid[i] <= 1'b0;
      end
    end else if (fin && wr_en) begin
      owner_valid[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && wr_en) begin
      owner_id[wr_idx]   <= item.src;
      voice_loud[wr_idx] <= wr_loud;
    end
  end

  assign out_valid_next = fin || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      action         <= res_action;
      voice          <= VOICE_W'(res_voice);
      evicted_source <= res_evicted;
    end
  end

  a_one_owner: assert property (@(posedge clk) disable iff (rst)
    $countones(match_vec) <= 1)
    else $error("source holds more than one voice");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && out_valid && out_stall) |=> state == ST_APPLY)
    else $error("result overwritten while stalled");

  a_fin_shows: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid)
    else $error("finished transaction not presented");

  a_free_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && free_any_q) |-> (CFG_W'(free_idx_q) < n_active))
    else $error("free voice outside active pool");

endmodule

FILE: hw/rtl/voice_allocator_steal_faintest.sv
// top level: config register, event front end and allocation back end
// an accepted event passes through the queue, the item register, the scan registers
// and the result register; the back end spends a scan state and an apply state
// on the voice table for each event, and the apply state waits while a result is stalled
// reset: synchronous, clears all voice occupancy at once, voices_in_use to 32,
// no clearing pass, so input is accepted as soon as reset is released
module voice_allocator_steal_faintest #(
  parameter int NUM_SOURCES = 256,
  parameter int NUM_VOICES  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vasf_pkg::SRC_W-1:0]   source_id,
  input  logic [vasf_pkg::LOUD_W-1:0]  loudness,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vasf_pkg::ACT_W-1:0]   action,
  output logic [vasf_pkg::VOICE_W-1:0] voice,
  output logic [vasf_pkg::SRC_W-1:0]   evicted_source,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vasf_pkg::*;

  logic [CFG_W-1:0] voices_in_use;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VOICES_IN_USE) ? {26'd0, voices_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      voices_in_use <= VOICES_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_VOICES_IN_USE)) begin
      voices_in_use <= pwdata[CFG_W-1:0];
    end
  end

  vasf_front #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .source_id (source_id),
    .loudness  (loudness),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  vasf_back #(
    .NUM_VOICES(NUM_VOICES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .voices_in_use  (voices_in_use),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .voice          (voice),
    .evicted_source (evicted_source)
  );

endmodule
